### rtl/core/lsa_pkg.sv
// Shared types, codes and helpers for the latency statistics accumulator.
package lsa_pkg;

  localparam int TIME_BITS = 24;
  localparam int CNT_W     = 64;
  localparam int SQ_W      = 2 * TIME_BITS;
  localparam int TRIES_W   = 16;
  localparam int IDX_W     = 5;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SQ_W-1:0]      sq_t;
  typedef logic [TRIES_W-1:0]   tries_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_SUCCESS       = 2'd0,
    STATUS_SERIALIZATION = 2'd1,
    STATUS_DEADLOCK      = 2'd2,
    STATUS_OTHER         = 2'd3
  } status_t;

  localparam idx_t IDX_SUCCESS     = 5'd0;
  localparam idx_t IDX_SKIPPED     = 5'd1;
  localparam idx_t IDX_RETRY_TOTAL = 5'd2;
  localparam idx_t IDX_RETRIED     = 5'd3;
  localparam idx_t IDX_SER_FAIL    = 5'd4;
  localparam idx_t IDX_DEAD_FAIL   = 5'd5;
  localparam idx_t IDX_OTHER_FAIL  = 5'd6;
  localparam idx_t IDX_FAIL_TOTAL  = 5'd7;
  localparam idx_t IDX_LAT_MIN     = 5'd8;
  localparam idx_t IDX_LAT_MAX     = 5'd9;
  localparam idx_t IDX_LAT_SUM     = 5'd10;
  localparam idx_t IDX_LAT_SQ_SUM  = 5'd11;
  localparam idx_t IDX_LAG_COUNT   = 5'd12;
  localparam idx_t IDX_LAG_MIN     = 5'd13;
  localparam idx_t IDX_LAG_MAX     = 5'd14;
  localparam idx_t IDX_LAG_SUM     = 5'd15;
  localparam idx_t IDX_LAG_SQ_SUM  = 5'd16;

  // Count, extremes and sums of one sampled quantity.
  typedef struct packed {
    cnt_t  count;
    time_t min_v;
    time_t max_v;
    cnt_t  sum;
    cnt_t  sq_sum;
  } sample_stats_t;

  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

### rtl/core/lsa_sample.sv
// Running count, min, max, sum and sum of squares for one sampled quantity.
module lsa_sample (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic                  clear,
  input  lsa_pkg::time_t        sample,
  input  lsa_pkg::sq_t          sample_sq,
  output lsa_pkg::sample_stats_t stats
);
  import lsa_pkg::*;

  sample_stats_t stats_r;
  sample_stats_t stats_nxt;
  logic          first;

  always_comb begin
    stats_nxt = stats_r;
    first     = (stats_r.count == '0);
    if (clear) begin
      stats_nxt = '0;
    end else if (take) begin
      if (first || sample < stats_r.min_v) begin
        stats_nxt.min_v = sample;
      end
      if (first || sample > stats_r.max_v) begin
        stats_nxt.max_v = sample;
      end
      stats_nxt.count  = sat_add(stats_r.count, CNT_W'(1));
      stats_nxt.sum    = sat_add(stats_r.sum, CNT_W'(sample));
      stats_nxt.sq_sum = sat_add(stats_r.sq_sum, CNT_W'(sample_sq));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r <= '0;
    end else begin
      stats_r <= stats_nxt;
    end
  end

  assign stats = stats_r;

endmodule

### rtl/core/latency_stats_accumulator.sv
// Top level of the latency statistics accumulator.
//
//  channel   | handshake             | word
//  ----------+-----------------------+-------------------------------------------
//  in_*      | in_valid / in_ready   | kind, skipped, latency, lag, status, ...
//  out_*     | out_valid / out_ready | stat_value, was_read
//
// Every word passes through the input register, where the squares of latency and
// lag are stored, and then the result register, loaded as the statistics update.
// One word per cycle is sustained while out_ready stays high.
// A stalled result holds the input register, which holds in_ready low.
// Synchronous active-low reset zeroes every statistic, as a clear word does.
module latency_stats_accumulator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_kind,
  input  logic            in_skipped,
  input  lsa_pkg::time_t  in_latency_us,
  input  lsa_pkg::time_t  in_lag_us,
  input  logic [1:0]      in_status,
  input  lsa_pkg::tries_t in_tries,
  input  logic            in_has_lag,
  input  lsa_pkg::idx_t   in_stat_index,
  output logic            out_valid,
  input  logic            out_ready,
  output lsa_pkg::cnt_t   out_stat_value,
  output logic            out_was_read
);
  import lsa_pkg::*;

  // Input register
  logic    s1_valid_r;
  kind_t   s1_kind_r;
  logic    s1_skipped_r;
  time_t   s1_lat_r;
  time_t   s1_lag_r;
  status_t s1_status_r;
  tries_t  s1_tries_r;
  logic    s1_has_lag_r;
  idx_t    s1_idx_r;
  sq_t     s1_lat_sq_r;
  sq_t     s1_lag_sq_r;

  // Result register
  logic out_valid_r;
  cnt_t out_stat_value_r;
  logic out_was_read_r;

  logic in_fire;
  logic s1_fire;
  logic do_record;
  logic do_clear;
  logic take_lat;
  logic take_lag;

  cnt_t skipped_cnt_r, skipped_cnt_nxt;
  cnt_t retry_total_r, retry_total_nxt;
  cnt_t retried_cnt_r, retried_cnt_nxt;
  cnt_t ser_cnt_r, ser_cnt_nxt;
  cnt_t dead_cnt_r, dead_cnt_nxt;
  cnt_t other_cnt_r, other_cnt_nxt;
  cnt_t fail_total_r, fail_total_nxt;

  sample_stats_t lat_stats;
  sample_stats_t lag_stats;
  cnt_t          read_value;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r    <= kind_t'(in_kind);
      s1_skipped_r <= in_skipped;
      s1_lat_r     <= in_latency_us;
      s1_lag_r     <= in_lag_us;
      s1_status_r  <= status_t'(in_status);
      s1_tries_r   <= in_tries;
      s1_has_lag_r <= in_has_lag;
      s1_idx_r     <= in_stat_index;
      s1_lat_sq_r  <= SQ_W'(in_latency_us) * SQ_W'(in_latency_us);
      s1_lag_sq_r  <= SQ_W'(in_lag_us) * SQ_W'(in_lag_us);
    end
  end

  assign do_record = s1_fire && (s1_kind_r == KIND_RECORD) && !s1_skipped_r;
  assign do_clear  = s1_fire && (s1_kind_r == KIND_CLEAR);
  assign take_lat  = do_record && (s1_status_r == STATUS_SUCCESS);
  assign take_lag  = take_lat && s1_has_lag_r;

  always_comb begin
    skipped_cnt_nxt = skipped_cnt_r;
    retry_total_nxt = retry_total_r;
    retried_cnt_nxt = retried_cnt_r;
    ser_cnt_nxt     = ser_cnt_r;
    dead_cnt_nxt    = dead_cnt_r;
    other_cnt_nxt   = other_cnt_r;
    fail_total_nxt  = fail_total_r;
    if (do_clear) begin
      skipped_cnt_nxt = '0;
      retry_total_nxt = '0;
      retried_cnt_nxt = '0;
      ser_cnt_nxt     = '0;
      dead_cnt_nxt    = '0;
      other_cnt_nxt   = '0;
      fail_total_nxt  = '0;
    end else if (s1_fire && (s1_kind_r == KIND_RECORD) && s1_skipped_r) begin
      skipped_cnt_nxt = sat_add(skipped_cnt_r, CNT_W'(1));
    end else if (do_record) begin
      if (s1_tries_r > TRIES_W'(1)) begin
        retry_total_nxt = sat_add(retry_total_r, CNT_W'(s1_tries_r - TRIES_W'(1)));
        retried_cnt_nxt = sat_add(retried_cnt_r, CNT_W'(1));
      end
      // The failure total only ever steps by one, so it saturates exactly
      // where the saturating sum of the three failure counts would.
      unique case (s1_status_r)
        STATUS_SUCCESS: begin
        end
        STATUS_SERIALIZATION: begin
          ser_cnt_nxt    = sat_add(ser_cnt_r, CNT_W'(1));
          fail_total_nxt = sat_add(fail_total_r, CNT_W'(1));
        end
        STATUS_DEADLOCK: begin
          dead_cnt_nxt   = sat_add(dead_cnt_r, CNT_W'(1));
          fail_total_nxt = sat_add(fail_total_r, CNT_W'(1));
        end
        STATUS_OTHER: begin
          other_cnt_nxt  = sat_add(other_cnt_r, CNT_W'(1));
          fail_total_nxt = sat_add(fail_total_r, CNT_W'(1));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skipped_cnt_r <= '0;
      retry_total_r <= '0;
      retried_cnt_r <= '0;
      ser_cnt_r     <= '0;
      dead_cnt_r    <= '0;
      other_cnt_r   <= '0;
      fail_total_r  <= '0;
    end else begin
      skipped_cnt_r <= skipped_cnt_nxt;
      retry_total_r <= retry_total_nxt;
      retried_cnt_r <= retried_cnt_nxt;
      ser_cnt_r     <= ser_cnt_nxt;
      dead_cnt_r    <= dead_cnt_nxt;
      other_cnt_r   <= other_cnt_nxt;
      fail_total_r  <= fail_total_nxt;
    end
  end

  lsa_sample u_lat (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take_lat),
    .clear     (do_clear),
    .sample    (s1_lat_r),
    .sample_sq (s1_lat_sq_r),
    .stats     (lat_stats)
  );

  lsa_sample u_lag (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take_lag),
    .clear     (do_clear),
    .sample    (s1_lag_r),
    .sample_sq (s1_lag_sq_r),
    .stats     (lag_stats)
  );

  always_comb begin
    unique case (s1_idx_r)
      IDX_SUCCESS:     read_value = lat_stats.count;
      IDX_SKIPPED:     read_value = skipped_cnt_r;
      IDX_RETRY_TOTAL: read_value = retry_total_r;
      IDX_RETRIED:     read_value = retried_cnt_r;
      IDX_SER_FAIL:    read_value = ser_cnt_r;
      IDX_DEAD_FAIL:   read_value = dead_cnt_r;
      IDX_OTHER_FAIL:  read_value = other_cnt_r;
      IDX_FAIL_TOTAL:  read_value = fail_total_r;
      IDX_LAT_MIN:     read_value = CNT_W'(lat_stats.min_v);
      IDX_LAT_MAX:     read_value = CNT_W'(lat_stats.max_v);
      IDX_LAT_SUM:     read_value = lat_stats.sum;
      IDX_LAT_SQ_SUM:  read_value = lat_stats.sq_sum;
      IDX_LAG_COUNT:   read_value = lag_stats.count;
      IDX_LAG_MIN:     read_value = CNT_W'(lag_stats.min_v);
      IDX_LAG_MAX:     read_value = CNT_W'(lag_stats.max_v);
      IDX_LAG_SUM:     read_value = lag_stats.sum;
      IDX_LAG_SQ_SUM:  read_value = lag_stats.sq_sum;
      default:         read_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_was_read_r   <= (s1_kind_r == KIND_READ);
      out_stat_value_r <= (s1_kind_r == KIND_READ) ? read_value : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_stat_value = out_stat_value_r;
  assign out_was_read   = out_was_read_r;

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (lat_stats.count == '0) && (lag_stats.count == '0) && (fail_total_r == '0))
    else $error("statistics not zero after a clear word");

  a_fail_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fail_total_r >= ser_cnt_r) && (fail_total_r >= dead_cnt_r) && (fail_total_r >= other_cnt_r))
    else $error("failure total below one of its parts");

  a_lag_within_success: assert property (@(posedge clk) disable iff (!rst_n)
    lag_stats.count <= lat_stats.count)
    else $error("lag count exceeds success count");

  a_lat_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (lat_stats.count != '0) |-> (lat_stats.min_v <= lat_stats.max_v))
    else $error("latency min above latency max");

  a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_was_read_r) |-> (out_stat_value_r == '0))
    else $error("nonzero value on a result that answers no read");

endmodule

### dv/stats_checker.sv
`timescale 1ns / 100ps
// Statistics predictor and result scoreboard for the latency statistics accumulator.
module stats_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [1:0]      in_kind,
  input  logic            in_skipped,
  input  lsa_pkg::time_t  in_latency_us,
  input  lsa_pkg::time_t  in_lag_us,
  input  logic [1:0]      in_status,
  input  lsa_pkg::tries_t in_tries,
  input  logic            in_has_lag,
  input  lsa_pkg::idx_t   in_stat_index,
  input  logic            out_valid,
  input  logic            out_ready,
  input  lsa_pkg::cnt_t   out_stat_value,
  input  logic            out_was_read,
  output int              mismatches,
  output int              replies_owed
);
  import lsa_pkg::*;

  typedef struct packed {
    cnt_t value;
    logic was_read;
  } reply_t;

  // The latency record's count doubles as the success count.
  sample_stats_t latency_st;
  sample_stats_t lag_st;
  cnt_t          skipped_n;
  cnt_t          retry_sum;
  cnt_t          retried_n;
  cnt_t          ser_fail_n;
  cnt_t          dead_fail_n;
  cnt_t          other_fail_n;
  reply_t        predicted_replies[$];

  // Sum that sticks at all ones once it would wrap.
  function automatic cnt_t clamp_add(cnt_t a, cnt_t b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  function automatic sample_stats_t fold_sample(sample_stats_t st, time_t v);
    cnt_t sq;
    sq = cnt_t'(v) * cnt_t'(v);
    if (st.count == '0 || v < st.min_v) begin
      st.min_v = v;
    end
    if (st.count == '0 || v > st.max_v) begin
      st.max_v = v;
    end
    st.count  = clamp_add(st.count, cnt_t'(1));
    st.sum    = clamp_add(st.sum, cnt_t'(v));
    st.sq_sum = clamp_add(st.sq_sum, sq);
    return st;
  endfunction

  function automatic cnt_t lookup_stat(idx_t idx);
    case (idx)
      IDX_SUCCESS:     return latency_st.count;
      IDX_SKIPPED:     return skipped_n;
      IDX_RETRY_TOTAL: return retry_sum;
      IDX_RETRIED:     return retried_n;
      IDX_SER_FAIL:    return ser_fail_n;
      IDX_DEAD_FAIL:   return dead_fail_n;
      IDX_OTHER_FAIL:  return other_fail_n;
      IDX_FAIL_TOTAL:  return clamp_add(clamp_add(ser_fail_n, dead_fail_n), other_fail_n);
      IDX_LAT_MIN:     return cnt_t'(latency_st.min_v);
      IDX_LAT_MAX:     return cnt_t'(latency_st.max_v);
      IDX_LAT_SUM:     return latency_st.sum;
      IDX_LAT_SQ_SUM:  return latency_st.sq_sum;
      IDX_LAG_COUNT:   return lag_st.count;
      IDX_LAG_MIN:     return cnt_t'(lag_st.min_v);
      IDX_LAG_MAX:     return cnt_t'(lag_st.max_v);
      IDX_LAG_SUM:     return lag_st.sum;
      IDX_LAG_SQ_SUM:  return lag_st.sq_sum;
      default:         return '0;
    endcase
  endfunction

  task automatic clear_stats();
    latency_st   = '0;
    lag_st       = '0;
    skipped_n    = '0;
    retry_sum    = '0;
    retried_n    = '0;
    ser_fail_n   = '0;
    dead_fail_n  = '0;
    other_fail_n = '0;
  endtask

  task automatic apply_record();
    if (in_skipped) begin
      skipped_n = clamp_add(skipped_n, cnt_t'(1));
    end else begin
      if (in_tries > tries_t'(1)) begin
        retry_sum = clamp_add(retry_sum, cnt_t'(in_tries - tries_t'(1)));
        retried_n = clamp_add(retried_n, cnt_t'(1));
      end
      case (in_status)
        STATUS_SUCCESS: begin
          latency_st = fold_sample(latency_st, in_latency_us);
          if (in_has_lag) begin
            lag_st = fold_sample(lag_st, in_lag_us);
          end
        end
        STATUS_SERIALIZATION: ser_fail_n = clamp_add(ser_fail_n, cnt_t'(1));
        STATUS_DEADLOCK:      dead_fail_n = clamp_add(dead_fail_n, cnt_t'(1));
        default:              other_fail_n = clamp_add(other_fail_n, cnt_t'(1));
      endcase
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      clear_stats();
      predicted_replies.delete();
      mismatches = 0;
    end else begin
      // A result can only answer a word taken at an earlier edge, so it is
      // checked before this edge's word is folded in.
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          $error("unexpected result: stat_value %0d, was_read %0b",
                 out_stat_value, out_was_read);
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_stat_value !== want.value) begin
            $error("stat_value: expected %0d, got %0d", want.value, out_stat_value);
            mismatches++;
          end
          if (out_was_read !== want.was_read) begin
            $error("was_read: expected %0b, got %0b", want.was_read, out_was_read);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = '0;
        case (in_kind)
          KIND_RECORD: apply_record();
          KIND_READ: begin
            want.value    = lookup_stat(in_stat_index);
            want.was_read = 1'b1;
          end
          KIND_CLEAR: clear_stats();
          default: ;
        endcase
        predicted_replies.push_back(want);
      end
    end
    replies_owed = predicted_replies.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Top of the latency statistics accumulator testbench: clock, reset, stimulus and verdict.
module testbench;
  import lsa_pkg::*;

  localparam logic [1:0] KIND_UNUSED      = 2'd3;
  localparam idx_t       IDX_FIRST_UNUSED = 5'd17;
  localparam idx_t       IDX_LAST_UNUSED  = 5'd31;
  localparam int         RANDOM_WORDS     = 1800;
  localparam int         HOLD_START       = 400;
  localparam int         HOLD_CYCLES      = 200;
  localparam int         DRAIN_CYCLES     = 10;

  typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_TOGGLE} drain_mode_t;

  typedef struct {
    logic [1:0] kind;
    logic       skipped;
    time_t      latency;
    time_t      lag;
    logic [1:0] status;
    tries_t     tries;
    logic       has_lag;
    idx_t       idx;
  } word_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic [1:0] in_kind;
  logic   in_skipped;
  time_t  in_latency_us;
  time_t  in_lag_us;
  logic [1:0] in_status;
  tries_t in_tries;
  logic   in_has_lag;
  idx_t   in_stat_index;
  logic   out_valid;
  logic   out_ready;
  cnt_t   out_stat_value;
  logic   out_was_read;
  int     mismatches;
  int     replies_owed;
  int     burst_left = 0;

  latency_stats_accumulator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_skipped     (in_skipped),
    .in_latency_us  (in_latency_us),
    .in_lag_us      (in_lag_us),
    .in_status      (in_status),
    .in_tries       (in_tries),
    .in_has_lag     (in_has_lag),
    .in_stat_index  (in_stat_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_stat_value (out_stat_value),
    .out_was_read   (out_was_read)
  );

  stats_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_skipped     (in_skipped),
    .in_latency_us  (in_latency_us),
    .in_lag_us      (in_lag_us),
    .in_status      (in_status),
    .in_tries       (in_tries),
    .in_has_lag     (in_has_lag),
    .in_stat_index  (in_stat_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_stat_value (out_stat_value),
    .out_was_read   (out_was_read),
    .mismatches     (mismatches),
    .replies_owed   (replies_owed)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic time_t pick_time();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return time_t'($urandom_range(0, 1000));
      default: return time_t'($urandom);
    endcase
  endfunction

  function automatic tries_t pick_tries();
    case ($urandom_range(0, 5))
      0:       return tries_t'(0);
      1:       return tries_t'(1);
      2:       return tries_t'($urandom_range(2, 4));
      3:       return '1;
      default: return tries_t'($urandom);
    endcase
  endfunction

  // Fields a word's kind does not use still carry random bits.
  function automatic word_t noise_word();
    word_t w;
    w.kind    = 2'($urandom);
    w.skipped = 1'($urandom);
    w.latency = time_t'($urandom);
    w.lag     = time_t'($urandom);
    w.status  = 2'($urandom);
    w.tries   = tries_t'($urandom);
    w.has_lag = 1'($urandom);
    w.idx     = idx_t'($urandom);
    return w;
  endfunction

  function automatic word_t kind_word(logic [1:0] kind);
    word_t w;
    w = noise_word();
    w.kind = kind;
    return w;
  endfunction

  function automatic word_t read_word(idx_t idx);
    word_t w;
    w = kind_word(KIND_READ);
    w.idx = idx;
    return w;
  endfunction

  function automatic word_t record_word(logic [1:0] status, time_t lat, time_t lag,
                                        tries_t tries, logic has_lag, logic skipped);
    word_t w;
    w = kind_word(KIND_RECORD);
    w.status  = status;
    w.latency = lat;
    w.lag     = lag;
    w.tries   = tries;
    w.has_lag = has_lag;
    w.skipped = skipped;
    return w;
  endfunction

  function automatic word_t random_word();
    int   pick;
    idx_t idx;
    logic [1:0] status;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      return kind_word(KIND_CLEAR);
    end else if (pick < 6) begin
      return kind_word(KIND_UNUSED);
    end else if (pick < 40) begin
      if ($urandom_range(0, 9) == 0) begin
        idx = idx_t'($urandom_range(IDX_FIRST_UNUSED, IDX_LAST_UNUSED));
      end else begin
        idx = idx_t'($urandom_range(IDX_SUCCESS, IDX_LAG_SQ_SUM));
      end
      return read_word(idx);
    end else begin
      if ($urandom_range(0, 9) < 6) begin
        status = STATUS_SUCCESS;
      end else begin
        status = 2'($urandom_range(STATUS_SERIALIZATION, STATUS_OTHER));
      end
      return record_word(status, pick_time(), pick_time(), pick_tries(),
                         1'($urandom), $urandom_range(0, 9) == 0);
    end
  endfunction

  task automatic send_word(word_t w);
    @(negedge clk);
    in_valid      = 1'b1;
    in_kind       = w.kind;
    in_skipped    = w.skipped;
    in_latency_us = w.latency;
    in_lag_us     = w.lag;
    in_status     = w.status;
    in_tries      = w.tries;
    in_has_lag    = w.has_lag;
    in_stat_index = w.idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // Back-to-back words within a burst, a short gap between bursts.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic send_paced(word_t w);
    send_word(w);
    pace();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_RECORD;
    in_skipped    = 1'b0;
    in_latency_us = '0;
    in_lag_us     = '0;
    in_status     = STATUS_SUCCESS;
    in_tries      = '0;
    in_has_lag    = 1'b0;
    in_stat_index = IDX_SUCCESS;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: empty read, extremes, each status, skip, unused codes.
    send_paced(read_word(IDX_LAT_MIN));
    send_paced(record_word(STATUS_SUCCESS, '0, '1, tries_t'(0), 1'b1, 1'b0));
    send_paced(record_word(STATUS_SUCCESS, '1, '0, tries_t'(1), 1'b1, 1'b0));
    send_paced(record_word(STATUS_SUCCESS, time_t'(5), time_t'(7), tries_t'(2), 1'b0, 1'b0));
    send_paced(record_word(STATUS_SERIALIZATION, pick_time(), pick_time(), '1, 1'b1, 1'b0));
    send_paced(record_word(STATUS_DEADLOCK, pick_time(), pick_time(), tries_t'(0), 1'b0, 1'b0));
    send_paced(record_word(STATUS_OTHER, pick_time(), pick_time(), tries_t'(3), 1'b1, 1'b0));
    send_paced(record_word(STATUS_SUCCESS, '1, '1, '1, 1'b1, 1'b1));
    send_paced(kind_word(KIND_UNUSED));
    send_paced(read_word(IDX_SUCCESS));
    send_paced(read_word(IDX_SKIPPED));
    send_paced(read_word(IDX_RETRY_TOTAL));
    send_paced(read_word(IDX_RETRIED));
    send_paced(read_word(IDX_FAIL_TOTAL));
    send_paced(read_word(IDX_LAT_MAX));
    send_paced(read_word(IDX_LAT_SQ_SUM));
    send_paced(read_word(IDX_LAG_COUNT));
    send_paced(read_word(IDX_LAG_MIN));
    send_paced(read_word(IDX_LAG_MAX));
    send_paced(read_word(IDX_LAG_SQ_SUM));
    send_paced(read_word(IDX_FIRST_UNUSED));
    send_paced(read_word(IDX_LAST_UNUSED));
    send_paced(kind_word(KIND_CLEAR));
    send_paced(read_word(IDX_LAT_MAX));

    repeat (RANDOM_WORDS) begin
      send_paced(random_word());
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (replies_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Result side: stretches of differing stall patterns, with one long
  // hold-off that backs the block up into its input.
  initial begin
    int          cyc;
    int          span;
    drain_mode_t mode;
    out_ready = 1'b0;
    cyc = 0;
    wait (rst_n === 1'b1);
    forever begin
      mode = drain_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 48);
      repeat (span) begin
        @(negedge clk);
        cyc++;
        if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
          out_ready = 1'b0;
        end else begin
          case (mode)
            DRAIN_FREE:   out_ready = 1'b1;
            DRAIN_COIN:   out_ready = 1'($urandom);
            DRAIN_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
            default:      out_ready = ~out_ready;
          endcase
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### filelist.f
rtl/core/lsa_pkg.sv
rtl/core/lsa_sample.sv
rtl/core/latency_stats_accumulator.sv
dv/stats_checker.sv
dv/testbench.sv
